@@ rtl/lfbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lfbs_pkg
// Shared constants, types and helpers of the LED FIFO brightness sequencer.
// ----------------------------------------------------------------------------
package lfbs_pkg;

  localparam int CHANNELS      = 4;
  localparam int FIFO_DEPTH    = 16;
  localparam int DURATION_BITS = 16;

  // fixed field widths of the item and result beats
  localparam int KIND_W     = 1;
  localparam int CHAN_IN_W  = 2;
  localparam int LEVEL_W    = 7;
  localparam int DUR_IN_W   = 16;
  localparam int SHOWN      = 4;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int DUR_W  = DURATION_BITS;
  localparam int MEM_DEPTH = CHANNELS * FIFO_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(100);
  localparam logic [KIND_W-1:0]  KIND_PUSH = 1'b0;
  localparam logic [KIND_W-1:0]  KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_TICK,
    S_APPLY,
    S_REPORT
  } lfbs_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PUSH,
    OP_TICK,
    OP_APPLY,
    OP_REPORT
  } lfbs_op_e;

  typedef struct packed {
    logic in_is_tick;
    logic need_pop;
    logic last_ch;
  } lfbs_status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   dur;
  } lfbs_entry_t;

  typedef struct packed {
    logic [SHOWN-1:0][LEVEL_W-1:0] levels;
    logic [SHOWN-1:0]              busy;
    logic                          rejected;
  } lfbs_result_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv);
    clamp_level = (lv > MAX_LEVEL) ? MAX_LEVEL : lv;
  endfunction

endpackage

@@ rtl/lfbs_if.sv @@
// ----------------------------------------------------------------------------
// lfbs_if
// Valid/ready channels of the sequencer: command items in, level reports out.
// ----------------------------------------------------------------------------
interface lfbs_item_if;
  logic                               valid;
  logic                               ready;
  logic [lfbs_pkg::KIND_W-1:0]        kind;
  logic [lfbs_pkg::CHAN_IN_W-1:0]     channel;
  logic [lfbs_pkg::LEVEL_W-1:0]       brightness;
  logic [lfbs_pkg::DUR_IN_W-1:0]      duration_ms;

  modport source (output valid, kind, channel, brightness, duration_ms, input ready);
  modport sink   (input valid, kind, channel, brightness, duration_ms, output ready);
endinterface

interface lfbs_result_if;
  logic                               valid;
  logic                               ready;
  logic [lfbs_pkg::LEVEL_W-1:0]       level_a;
  logic [lfbs_pkg::LEVEL_W-1:0]       level_b;
  logic [lfbs_pkg::LEVEL_W-1:0]       level_c;
  logic [lfbs_pkg::LEVEL_W-1:0]       level_d;
  logic [3:0]                         busy_mask;
  logic                               push_rejected;

  modport source (output valid, level_a, level_b, level_c, level_d, busy_mask,
                  push_rejected, input ready);
  modport sink   (input valid, level_a, level_b, level_c, level_d, busy_mask,
                  push_rejected, output ready);
endinterface

@@ rtl/lfbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfbs_ctrl
// Sequencer state machine: takes a beat, steps the datapath through the push
// or the per-channel tick walk, and holds the result beat until taken.
// ----------------------------------------------------------------------------
module lfbs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  lfbs_pkg::lfbs_status_t sts_i,
  output lfbs_pkg::lfbs_op_e     op_o
);
  import lfbs_pkg::*;

  lfbs_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = sts_i.in_is_tick ? S_TICK : S_PUSH;
        end
      end
      S_PUSH:   state_d = S_IDLE;
      S_TICK: begin
        if (sts_i.need_pop) begin
          state_d = S_APPLY;
        end else if (sts_i.last_ch) begin
          state_d = S_REPORT;
        end
      end
      S_APPLY:  state_d = sts_i.last_ch ? S_REPORT : S_TICK;
      S_REPORT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o = OP_NONE;
    case (state_q)
      S_IDLE:   op_o = accept ? OP_CAPTURE : OP_NONE;
      S_PUSH:   op_o = OP_PUSH;
      S_TICK:   op_o = OP_TICK;
      S_APPLY:  op_o = OP_APPLY;
      S_REPORT: op_o = OP_REPORT;
      default:  op_o = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_PUSH || state_q == S_REPORT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/lfbs_datapath.sv @@
// ----------------------------------------------------------------------------
// lfbs_datapath
// Command store, per-channel FIFO pointers, countdowns and shown levels,
// plus the captured item and the result register.
// ----------------------------------------------------------------------------
module lfbs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfbs_pkg::lfbs_op_e                  op_i,
  input  logic [lfbs_pkg::KIND_W-1:0]         kind_i,
  input  logic [lfbs_pkg::CHAN_IN_W-1:0]      channel_i,
  input  logic [lfbs_pkg::LEVEL_W-1:0]        brightness_i,
  input  logic [lfbs_pkg::DUR_IN_W-1:0]       duration_ms_i,
  output lfbs_pkg::lfbs_status_t              sts_o,
  output lfbs_pkg::lfbs_result_t              result_o
);
  import lfbs_pkg::*;

  lfbs_entry_t mem [MEM_DEPTH];
  lfbs_entry_t rd_q;

  logic [CHAN_IN_W-1:0] chan_q;
  logic [LEVEL_W-1:0]   bright_q;
  logic [DUR_W-1:0]     dur_q;

  logic [PTR_W-1:0]   rp_q    [CHANNELS];
  logic [PTR_W-1:0]   wp_q    [CHANNELS];
  logic [FILL_W-1:0]  fill_q  [CHANNELS];
  logic [DUR_W-1:0]   ticks_q [CHANNELS];
  logic [LEVEL_W-1:0] level_q [CHANNELS];
  logic [CH_W-1:0]    ch_q;

  lfbs_result_t res_q;

  logic [CH_W-1:0]   push_ch;
  logic              push_rej;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DUR_W-1:0]  t_dec;
  logic              need_pop;
  lfbs_result_t      res_now;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ch  = CH_W'(chan_q);
  assign push_rej = (32'(chan_q) >= CHANNELS) ||
                    (fill_q[push_ch] >= FILL_W'(FIFO_DEPTH));
  assign wr_addr  = ADDR_W'(push_ch) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(wp_q[push_ch]);
  assign rd_addr  = ADDR_W'(ch_q) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(rp_q[ch_q]);

  assign t_dec    = (ticks_q[ch_q] != '0) ? ticks_q[ch_q] - DUR_W'(1) : '0;
  assign need_pop = (t_dec == '0) && (fill_q[ch_q] != '0);

  assign sts_o.in_is_tick = (kind_i == KIND_TICK);
  assign sts_o.need_pop   = need_pop;
  assign sts_o.last_ch    = (ch_q == CH_W'(CHANNELS - 1));

  // command store
  always_ff @(posedge clk_i) begin
    if (op_i == OP_PUSH && !push_rej) begin
      mem[wr_addr] <= '{level: bright_q, dur: dur_q};
    end
    if (op_i == OP_TICK && need_pop) begin
      rd_q <= mem[rd_addr];
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (op_i == OP_CAPTURE) begin
      chan_q   <= channel_i;
      bright_q <= brightness_i;
      dur_q    <= DUR_W'(duration_ms_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rp_q[c]    <= '0;
        wp_q[c]    <= '0;
        fill_q[c]  <= '0;
        ticks_q[c] <= '0;
        level_q[c] <= '0;
      end
    end else begin
      case (op_i)
        OP_CAPTURE: ch_q <= '0;
        OP_PUSH: begin
          if (!push_rej) begin
            wp_q[push_ch]   <= ptr_inc(wp_q[push_ch]);
            fill_q[push_ch] <= fill_q[push_ch] + FILL_W'(1);
          end
        end
        OP_TICK: begin
          if (t_dec != '0) begin
            ticks_q[ch_q] <= t_dec;
            ch_q          <= ch_q + CH_W'(1);
          end else if (!need_pop) begin
            ticks_q[ch_q] <= '0;
            level_q[ch_q] <= '0;
            ch_q          <= ch_q + CH_W'(1);
          end
        end
        OP_APPLY: begin
          level_q[ch_q] <= clamp_level(rd_q.level);
          ticks_q[ch_q] <= (rd_q.dur == '0) ? DUR_W'(1) : rd_q.dur;
          rp_q[ch_q]    <= ptr_inc(rp_q[ch_q]);
          fill_q[ch_q]  <= fill_q[ch_q] - FILL_W'(1);
          ch_q          <= ch_q + CH_W'(1);
        end
        default: ;
      endcase
    end
  end

  // report only the first four channels, missing ones read as dark
  always_comb begin
    res_now = '0;
    for (int s = 0; s < SHOWN; s++) begin
      if (s < CHANNELS) begin
        res_now.levels[s] = level_q[s];
        res_now.busy[s]   = (ticks_q[s] != '0);
      end
    end
    res_now.rejected = (op_i == OP_PUSH) && push_rej;
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PUSH || op_i == OP_REPORT) begin
      res_q <= res_now;
    end
  end

  assign result_o = res_q;

endmodule

@@ rtl/led_fifo_brightness_sequencer.sv @@
// ----------------------------------------------------------------------------
// led_fifo_brightness_sequencer
// Per-channel FIFOs of brightness/duration commands played out on millisecond
// ticks; one report beat per item with the shown levels and busy bits.
// ----------------------------------------------------------------------------
// One item at a time. A push passes from acceptance through the push state,
// which writes the command store, to its result beat. A tick walks the
// channels one at a time; each channel that pops its next command also passes
// through the apply state after the registered read of the single-port command
// store. A new item is taken while the previous result beat is being taken in
// the same cycle.
module led_fifo_brightness_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfbs_item_if.sink     item_i,
  lfbs_result_if.source result_o
);
  import lfbs_pkg::*;

  lfbs_status_t sts;
  lfbs_op_e     op;
  lfbs_result_t res;

  lfbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .op_o        (op)
  );

  lfbs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .kind_i        (item_i.kind),
    .channel_i     (item_i.channel),
    .brightness_i  (item_i.brightness),
    .duration_ms_i (item_i.duration_ms),
    .sts_o         (sts),
    .result_o      (res)
  );

  assign result_o.level_a       = res.levels[0];
  assign result_o.level_b       = res.levels[1];
  assign result_o.level_c       = res.levels[2];
  assign result_o.level_d       = res.levels[3];
  assign result_o.busy_mask     = res.busy;
  assign result_o.push_rejected = res.rejected;

endmodule

@@ tb/tb_led_fifo_brightness_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_fifo_brightness_sequencer
// Drives push and tick beats into the sequencer and checks every report beat
// against a cycle-free model of the per-channel command FIFOs and countdowns.
// Stimulus is a short directed part followed by random segments of mixed
// traffic, FIFO fill bursts and tick runs. Both sides idle in random bursts,
// and the tail of the run goes without gaps.
// ----------------------------------------------------------------------------
module tb_led_fifo_brightness_sequencer;
  import lfbs_pkg::*;

  localparam int RANDOM_BEATS = 1400;
  localparam int CALM_BEATS   = 150;
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CHAN_IN_W-1:0] channel;
    logic [LEVEL_W-1:0]   brightness;
    logic [DUR_IN_W-1:0]  duration_ms;
  } cmd_beat_t;

  typedef struct {
    lfbs_entry_t        store [MEM_DEPTH];
    int unsigned        rd_ptr [CHANNELS];
    int unsigned        wr_ptr [CHANNELS];
    int unsigned        fill [CHANNELS];
    logic [DUR_W-1:0]   hold_left [CHANNELS];
    logic [LEVEL_W-1:0] shown [CHANNELS];
  } seq_state_t;

  logic clk_i;
  logic rst_ni;

  lfbs_item_if   item_bus ();
  lfbs_result_if result_bus ();

  led_fifo_brightness_sequencer u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  cmd_beat_t    pending_beats [$];
  lfbs_result_t level_expect [$];
  seq_state_t   plan_state;
  seq_state_t   live_state;

  int  fail_count;
  int  cycle_count;
  int  gap_pct;
  int  gap_left;
  int  stall_left;
  bit  item_taken;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void clear_sequencer(output seq_state_t st);
    for (int i = 0; i < MEM_DEPTH; i++) begin
      st.store[i] = '0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      st.rd_ptr[c]    = 0;
      st.wr_ptr[c]    = 0;
      st.fill[c]      = 0;
      st.hold_left[c] = '0;
      st.shown[c]     = '0;
    end
  endfunction

  // apply one beat and return the report it produces
  function automatic lfbs_result_t step_sequencer(inout seq_state_t st, input cmd_beat_t b);
    lfbs_result_t rep;
    lfbs_entry_t  ent;
    int           ch;
    int           slot;
    rep = '0;
    ch  = int'(b.channel);
    if (b.kind == KIND_PUSH) begin
      if (ch >= CHANNELS || st.fill[ch] >= FIFO_DEPTH) begin
        rep.rejected = 1'b1;
      end else begin
        slot = ch * FIFO_DEPTH + st.wr_ptr[ch];
        ent.level = b.brightness;
        ent.dur   = DUR_W'(b.duration_ms);
        st.store[slot] = ent;
        st.wr_ptr[ch] = (st.wr_ptr[ch] + 1) % FIFO_DEPTH;
        st.fill[ch]++;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (st.hold_left[c] != 0) st.hold_left[c]--;
        if (st.hold_left[c] == 0) begin
          if (st.fill[c] > 0) begin
            ent = st.store[c * FIFO_DEPTH + st.rd_ptr[c]];
            st.shown[c]     = (ent.level > MAX_LEVEL) ? MAX_LEVEL : ent.level;
            st.hold_left[c] = (ent.dur == 0) ? DUR_W'(1) : ent.dur;
            st.rd_ptr[c]    = (st.rd_ptr[c] + 1) % FIFO_DEPTH;
            st.fill[c]--;
          end else begin
            st.shown[c] = '0;
          end
        end
      end
    end
    for (int c = 0; c < SHOWN; c++) begin
      if (c < CHANNELS) begin
        rep.levels[c] = st.shown[c];
        rep.busy[c]   = (st.hold_left[c] != 0);
      end
    end
    return rep;
  endfunction

  task automatic queue_beat(input logic [KIND_W-1:0] kind, input int ch, input int br,
                            input int dur);
    cmd_beat_t b;
    b.kind        = kind;
    b.channel     = CHAN_IN_W'(ch);
    b.brightness  = LEVEL_W'(br);
    b.duration_ms = DUR_IN_W'(dur);
    void'(step_sequencer(plan_state, b));
    pending_beats.push_back(b);
  endtask

  // payload of a tick is ignored, so it carries noise
  task automatic queue_tick();
    queue_beat(KIND_TICK, $urandom_range(0, 3), $urandom_range(0, 127),
               $urandom_range(0, 65535));
  endtask

  // pushes that will land get short holds; ones bound for a full fifo get any duration
  task automatic queue_push(input int ch);
    int dur;
    int pick;
    pick = $urandom_range(0, 9);
    if (ch >= CHANNELS || plan_state.fill[ch] >= FIFO_DEPTH) dur = $urandom_range(0, 65535);
    else if (pick < 6) dur = $urandom_range(0, 3);
    else if (pick < 9) dur = $urandom_range(4, 24);
    else dur = $urandom_range(25, 200);
    queue_beat(KIND_PUSH, ch, $urandom_range(0, 127), dur);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // stimulus
  initial begin
    int n;
    int ch;
    item_bus.valid       = 1'b0;
    item_bus.kind        = KIND_PUSH;
    item_bus.channel     = '0;
    item_bus.brightness  = '0;
    item_bus.duration_ms = '0;
    result_bus.ready     = 1'b0;
    rst_ni               = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    gap_pct     = 0;
    gap_left    = 0;
    stall_left  = 0;
    item_taken  = 1'b0;
    clear_sequencer(plan_state);
    clear_sequencer(live_state);

    // directed: empty tick, clamp edges, zero duration, full fifo
    queue_tick();
    queue_beat(KIND_PUSH, 0, 127, 0);
    queue_beat(KIND_PUSH, 1, 100, 1);
    queue_beat(KIND_PUSH, 2, 101, 2);
    queue_beat(KIND_PUSH, 3, 0, 3);
    queue_tick();
    queue_tick();
    queue_tick();
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      queue_beat(KIND_PUSH, 1, (i * 9) % 128, i % 3);
    end
    queue_beat(KIND_PUSH, 1, 127, 65535);

    while (pending_beats.size() < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(10, 40);
          repeat (n) begin
            if ($urandom_range(0, 1) == 1) queue_tick();
            else queue_push($urandom_range(0, 3));
          end
        end
        4, 5: begin
          ch = $urandom_range(0, 3);
          n  = $urandom_range(12, 20);
          repeat (n) queue_push(ch);
        end
        default: begin
          n = $urandom_range(5, 30);
          repeat (n) queue_tick();
        end
      endcase
    end

    // longest hold goes last so no channel is stuck for the run
    queue_beat(KIND_PUSH, 3, 55, 65535);
    queue_tick();
    queue_tick();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_beats.size() != 0 || item_bus.valid) @(posedge clk_i);
    while (level_expect.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // driver
  always @(negedge clk_i) begin
    cmd_beat_t b;
    if (rst_ni) begin
      if (!item_bus.valid || item_taken) begin
        if (gap_left > 0) begin
          item_bus.valid <= 1'b0;
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          item_bus.kind        <= b.kind;
          item_bus.channel     <= b.channel;
          item_bus.brightness  <= b.brightness;
          item_bus.duration_ms <= b.duration_ms;
          item_bus.valid       <= 1'b1;
          if (pending_beats.size() >= CALM_BEATS && $urandom_range(0, 99) < gap_pct)
            gap_left = $urandom_range(1, 16);
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // report sink back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else if (pending_beats.size() >= CALM_BEATS && $urandom_range(0, 199) < gap_pct) begin
        result_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    lfbs_result_t want;
    cmd_beat_t    b;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        if (level_expect.size() == 0) begin
          fail_count++;
          $error("report beat with no pending expectation");
        end else begin
          want = level_expect.pop_front();
          check_field("level_a", want.levels[0], result_bus.level_a);
          check_field("level_b", want.levels[1], result_bus.level_b);
          check_field("level_c", want.levels[2], result_bus.level_c);
          check_field("level_d", want.levels[3], result_bus.level_d);
          check_field("busy_mask", want.busy, result_bus.busy_mask);
          check_field("push_rejected", want.rejected, result_bus.push_rejected);
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        item_taken    = 1'b1;
        b.kind        = item_bus.kind;
        b.channel     = item_bus.channel;
        b.brightness  = item_bus.brightness;
        b.duration_ms = item_bus.duration_ms;
        level_expect.push_back(step_sequencer(live_state, b));
      end
    end
  end

  // idle mix is redrawn from three gap percentages; run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 128 == 0) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
rtl/lfbs_pkg.sv
rtl/lfbs_if.sv
rtl/lfbs_ctrl.sv
rtl/lfbs_datapath.sv
rtl/led_fifo_brightness_sequencer.sv
tb/tb_led_fifo_brightness_sequencer.sv
